@@ hdl/mspi_pkg.sv @@
// Shared types, widths, register indexes and reset values of the PI speed controller.
// No dependencies; every other file of the block imports this package.
package mspi_pkg;

  localparam int SPEED_W   = 24;
  localparam int PULSE_W   = 12;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 23;
  localparam int TOUT_W    = 8;
  localparam int DRIVE_W   = 10;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;

  // Fraction bits of the count-to-speed factor and of the gains.
  localparam int CTS_FRAC  = 12;
  localparam int GAIN_FRAC = 8;

  localparam int ERR_W   = SPEED_W + 1;
  localparam int SUM_W   = SPEED_W + 2;
  localparam int INNER_W = 43;

  localparam int MPLR_W  = GAIN_W;
  localparam int MCAND_W = INNER_W;
  localparam int PROD_W  = MCAND_W + MPLR_W;

  localparam logic [SPEED_W-2:0] SPEED_MAX = '1;

  localparam int DUTY_MAX_DEF   = 1023;
  localparam int SPEED_FRAC_DEF = 12;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd3840;
  localparam logic [GAIN_W-1:0]  INT_GAIN_RST    = 16'd4608;
  localparam logic [GAIN_W-1:0]  TICK_PERIOD_RST = 16'd3277;
  localparam logic [GAIN_W-1:0]  CTS_RST         = 16'd2523;
  localparam logic [LIMIT_W-1:0] ACC_LIMIT_RST   = 23'd4096000;
  localparam logic [TOUT_W-1:0]  TIMEOUT_RST     = 8'd4;

  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INT_GAIN    = 3'd1,
    CFG_TICK_PERIOD = 3'd2,
    CFG_CTS         = 3'd3,
    CFG_ACC_LIMIT   = 3'd4,
    CFG_TIMEOUT     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPEED_MUL,
    S_INT_MUL,
    S_INNER_MUL,
    S_TOTAL_MUL,
    S_DUTY,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [DRIVE_W-1:0] fwd;
    logic [DRIVE_W-1:0] rev;
    logic               neg;
  } duty_t;

endpackage

@@ hdl/mspi_serial_mul.sv @@
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle, MSB first.
// Depends on mspi_pkg for the operand and product widths.
module mspi_serial_mul
  import mspi_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [MCAND_W-1:0] mcand_i,
  input  logic        [MPLR_W-1:0]  mplr_i,
  output logic                      done_o,
  output logic signed [PROD_W-1:0]  prod_o
);

  localparam int CNT_W = $clog2(MPLR_W + 1);

  logic signed [MCAND_W-1:0] mcand_q;
  logic        [MPLR_W-1:0]  mplr_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic signed [PROD_W-1:0]  acc_d;
  logic signed [PROD_W-1:0]  addend;
  logic        [CNT_W-1:0]   cnt_q;
  logic                      done_q;
  logic                      busy;

  assign busy   = (cnt_q != '0);
  assign addend = mplr_q[MPLR_W-1] ? PROD_W'(mcand_q) : '0;
  assign acc_d  = (acc_q <<< 1) + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(MPLR_W);
      end else if (busy) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      mplr_q  <= mplr_i;
      acc_q   <= '0;
    end else if (busy) begin
      mplr_q <= mplr_q << 1;
      acc_q  <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ hdl/mspi_duty.sv @@
// Duty stage: scales the loop total to a duty, saturates it and splits it onto the drives.
// Depends on mspi_pkg for the product width and the duty_t result type.
module mspi_duty
  import mspi_pkg::*;
#(
  parameter int FRAC_BITS = SPEED_FRAC_DEF,
  parameter int DUTY_MAX  = DUTY_MAX_DEF
) (
  input  logic signed [PROD_W-1:0] total_i,
  input  logic                     last_neg_i,
  output duty_t                    res_o
);

  localparam int SHIFT  = FRAC_BITS + MPLR_W;
  localparam int MAG_W  = $clog2(DUTY_MAX + 1);
  localparam int DUTY_W = ((MAG_W >= DRIVE_W) ? MAG_W : DRIVE_W) + 1;

  localparam logic signed [PROD_W-1:0] ROUND  = {{(PROD_W - SHIFT){1'b0}}, {SHIFT{1'b1}}};
  localparam logic signed [PROD_W-1:0] LIM_HI = PROD_W'(DUTY_MAX);
  localparam logic signed [PROD_W-1:0] LIM_LO = -LIM_HI;
  localparam logic signed [DUTY_W-1:0] DMAX   = DUTY_W'(DUTY_MAX);

  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] quot;
  logic signed [DUTY_W-1:0] duty;
  logic        [DUTY_W-1:0] mag;
  logic                     neg;

  // Adding 2^SHIFT - 1 to a negative total makes the arithmetic shift round toward zero.
  assign biased = total_i + (total_i[PROD_W-1] ? ROUND : '0);
  assign quot   = biased >>> SHIFT;

  always_comb begin
    if (quot > LIM_HI) begin
      duty = DMAX;
    end else if (quot < LIM_LO) begin
      duty = -DMAX;
    end else begin
      duty = DUTY_W'(quot);
    end
  end

  assign neg = duty[DUTY_W-1];
  assign mag = neg ? DUTY_W'(-duty) : DUTY_W'(duty);

  always_comb begin
    res_o     = '0;
    res_o.neg = neg;
    if (neg == last_neg_i) begin
      if (neg) begin
        res_o.rev = mag[DRIVE_W-1:0];
      end else begin
        res_o.fwd = mag[DRIVE_W-1:0];
      end
    end
  end

endmodule

@@ hdl/motor_speed_pi_duty_controller.sv @@
// Top level of the motor speed PI controller: sequencer, loop state and output register.
// Depends on mspi_pkg, mspi_serial_mul and mspi_duty.

// A command item (mode 0) stores a signed Q11.12 target speed and clears the idle tick
// count; it is taken while idle and gives no result. A tick item (mode 1) converts the
// encoder pulse count into a speed signed like the target and then either frees the motor,
// when more ticks than timeout_ticks have passed without a command, or runs one PI step
// and sets the forward and reverse duties; each tick gives one result transfer. A change
// of duty sign holds both drives at zero for one tick. All four products of a tick
// (pulses times count_to_speed, error times tick_period, accumulator times integral_gain
// and the loop total times prop_gain) share one bit-serial multiplier that takes one bit
// of the 16-bit gain per cycle. A tick runs the four products in turn, then the duty and
// output states; a timed-out tick skips from the first product to output. The sequencer
// handles one tick at a time; a finished result sits in the output register, so the next
// item can be taken while that result still waits. Configuration registers are written
// through the plain write port and must only be changed while no tick is in progress.
module motor_speed_pi_duty_controller
  import mspi_pkg::*;
#(
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_DEF,
  parameter int DUTY_MAX        = DUTY_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [CFG_W-1:0]   cfg_data_i,
  // Input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic signed [SPEED_W-1:0] target_speed_i,
  input  logic        [PULSE_W-1:0] pulse_count_i,
  // Result channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic        [DRIVE_W-1:0] drive_forward_o,
  output logic        [DRIVE_W-1:0] drive_reverse_o,
  output logic                      driver_enable_o,
  output logic signed [SPEED_W-1:0] measured_speed_o,
  output logic                      timed_out_o
);

  // Scaling of the pulse product from the 12 fraction bits of count_to_speed to the
  // fraction bits of the speed format.
  localparam int UP    = (SPEED_FRAC_BITS >= CTS_FRAC) ? SPEED_FRAC_BITS - CTS_FRAC : 0;
  localparam int DN    = (SPEED_FRAC_BITS >= CTS_FRAC) ? 0 : CTS_FRAC - SPEED_FRAC_BITS;
  localparam int RAW_W = PULSE_W + GAIN_W;
  localparam int SCL_W = RAW_W + UP;
  localparam int MAG_W = SPEED_W - 1;

  // Configuration registers.
  logic [GAIN_W-1:0]  prop_gain_q;
  logic [GAIN_W-1:0]  integral_gain_q;
  logic [GAIN_W-1:0]  tick_period_q;
  logic [GAIN_W-1:0]  count_to_speed_q;
  logic [LIMIT_W-1:0] accum_limit_q;
  logic [TOUT_W-1:0]  timeout_ticks_q;

  // Loop state.
  logic signed [SPEED_W-1:0] integ_q;
  logic signed [SPEED_W-1:0] target_q;
  logic                      last_neg_q;
  logic        [TOUT_W-1:0]  idle_q;
  logic                      en_q;

  // Sequencer.
  state_e state_q;
  state_e state_d;
  logic   mul_start_q;
  logic   mul_start_d;
  logic   in_take;
  logic   load_out;
  logic   out_valid_q;

  // Working registers of one tick.
  logic        [PULSE_W-1:0] pulse_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [INNER_W-1:0] inner_q;
  logic signed [PROD_W-1:0]  total_q;
  duty_t                     res_q;
  logic                      res_tout_q;

  // Multiplier connections.
  logic signed [MCAND_W-1:0] mul_mcand;
  logic        [MPLR_W-1:0]  mul_mplr;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_prod;

  // Combinational datapath.
  logic        [RAW_W-1:0]   raw;
  logic        [SCL_W-1:0]   scaled;
  logic        [MAG_W-1:0]   speed_mag;
  logic signed [SPEED_W-1:0] speed_d;
  logic signed [ERR_W-1:0]   err_d;
  logic signed [SUM_W-1:0]   sum_d;
  logic signed [INNER_W-1:0] inner_d;
  logic signed [SUM_W-1:0]   lim_pos;
  logic signed [SUM_W-1:0]   lim_neg;
  logic signed [SUM_W-1:0]   sum_clamped;
  logic                      timeout_hit;
  duty_t                     duty_res;

  mspi_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .mcand_i (mul_mcand),
    .mplr_i  (mul_mplr),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  mspi_duty #(
    .FRAC_BITS (SPEED_FRAC_BITS),
    .DUTY_MAX  (DUTY_MAX)
  ) u_duty (
    .total_i    (total_q),
    .last_neg_i (last_neg_q),
    .res_o      (duty_res)
  );

  // The pulse product is unsigned and at most 28 bits; the speed magnitude saturates to
  // the largest positive Q11.12 value before it takes the sign of the target.
  assign raw       = mul_prod[RAW_W-1:0];
  assign scaled    = (SCL_W'(raw) << UP) >> DN;
  assign speed_mag = (scaled > SCL_W'(SPEED_MAX)) ? SPEED_MAX : scaled[MAG_W-1:0];
  assign speed_d   = target_q[SPEED_W-1] ? -$signed({1'b0, speed_mag})
                                         :  $signed({1'b0, speed_mag});
  assign err_d     = ERR_W'(target_q) - ERR_W'(speed_d);
  assign timeout_hit = (idle_q > timeout_ticks_q);

  // The arithmetic shift of error times period is the floor the integrator needs.
  assign sum_d   = SUM_W'(integ_q) + SUM_W'(mul_prod >>> MPLR_W);
  assign inner_d = (INNER_W'(err_q) <<< GAIN_FRAC) + INNER_W'(mul_prod);

  assign lim_pos = $signed({{(SUM_W - LIMIT_W){1'b0}}, accum_limit_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (sum_q > lim_pos) begin
      sum_clamped = lim_pos;
    end else if (sum_q < lim_neg) begin
      sum_clamped = lim_neg;
    end else begin
      sum_clamped = sum_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (mode_i == MODE_TICK)) begin
          state_d = S_SPEED_MUL;
        end
      end
      S_SPEED_MUL: begin
        if (mul_done) begin
          state_d = timeout_hit ? S_OUT : S_INT_MUL;
        end
      end
      S_INT_MUL: begin
        if (mul_done) begin
          state_d = S_INNER_MUL;
        end
      end
      S_INNER_MUL: begin
        if (mul_done) begin
          state_d = S_TOTAL_MUL;
        end
      end
      S_TOTAL_MUL: begin
        if (mul_done) begin
          state_d = S_DUTY;
        end
      end
      S_DUTY: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake, multiplier start and operand selection.
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    in_take     = (state_q == S_IDLE) && in_valid_i;
    load_out    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
    mul_start_d = (state_d != state_q) &&
                  ((state_d == S_SPEED_MUL) || (state_d == S_INT_MUL) ||
                   (state_d == S_INNER_MUL) || (state_d == S_TOTAL_MUL));
    mul_mcand   = '0;
    mul_mplr    = '0;
    case (state_q)
      S_SPEED_MUL: begin
        mul_mcand = MCAND_W'($signed({1'b0, pulse_q}));
        mul_mplr  = count_to_speed_q;
      end
      S_INT_MUL: begin
        mul_mcand = MCAND_W'(err_q);
        mul_mplr  = tick_period_q;
      end
      S_INNER_MUL: begin
        mul_mcand = MCAND_W'(sum_q);
        mul_mplr  = integral_gain_q;
      end
      S_TOTAL_MUL: begin
        mul_mcand = inner_q;
        mul_mplr  = prop_gain_q;
      end
      default: begin
        mul_mcand = '0;
        mul_mplr  = '0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q      <= PROP_GAIN_RST;
      integral_gain_q  <= INT_GAIN_RST;
      tick_period_q    <= TICK_PERIOD_RST;
      count_to_speed_q <= CTS_RST;
      accum_limit_q    <= ACC_LIMIT_RST;
      timeout_ticks_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:   prop_gain_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_INT_GAIN:    integral_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_TICK_PERIOD: tick_period_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_CTS:         count_to_speed_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ACC_LIMIT:   accum_limit_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_TIMEOUT:     timeout_ticks_q  <= cfg_data_i[TOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      target_q    <= '0;
      last_neg_q  <= 1'b0;
      idle_q      <= '0;
      en_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_start_q <= mul_start_d;

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_take) begin
        if (mode_i == MODE_TICK) begin
          if (idle_q != '1) begin
            idle_q <= idle_q + TOUT_W'(1);
          end
        end else begin
          target_q <= target_speed_i;
          idle_q   <= '0;
        end
      end

      if ((state_q == S_SPEED_MUL) && mul_done && timeout_hit) begin
        target_q <= '0;
        integ_q  <= '0;
        en_q     <= 1'b0;
      end

      // The integrator takes the clamped sum only after the integral-gain product has used the sum.
      if ((state_q == S_INNER_MUL) && mul_done) begin
        integ_q <= SPEED_W'(sum_clamped);
      end

      if (state_q == S_DUTY) begin
        last_neg_q <= duty_res.neg;
        en_q       <= 1'b1;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pulse_q <= pulse_count_i;
    end

    case (state_q)
      S_SPEED_MUL: begin
        if (mul_done) begin
          speed_q <= speed_d;
          err_q   <= err_d;
          if (timeout_hit) begin
            res_q      <= '0;
            res_tout_q <= 1'b1;
          end
        end
      end
      S_INT_MUL: begin
        if (mul_done) begin
          sum_q <= sum_d;
        end
      end
      S_INNER_MUL: begin
        if (mul_done) begin
          inner_q <= inner_d;
        end
      end
      S_TOTAL_MUL: begin
        if (mul_done) begin
          total_q <= mul_prod;
        end
      end
      S_DUTY: begin
        res_q      <= duty_res;
        res_tout_q <= 1'b0;
      end
      default: begin
      end
    endcase

    if (load_out) begin
      drive_forward_o  <= res_q.fwd;
      drive_reverse_o  <= res_q.rev;
      driver_enable_o  <= en_q;
      measured_speed_o <= speed_q;
      timed_out_o      <= res_tout_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A result only appears after the sequencer has passed through its output state.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result transfer offered without a finished tick");

  // Never drive both half-bridges at once.
  a_drive_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_forward_o == '0) || (drive_reverse_o == '0))
    else $error("forward and reverse duty both non-zero");

  // A timed-out tick frees the motor completely.
  a_timeout_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |->
      (!driver_enable_o && (drive_forward_o == '0) && (drive_reverse_o == '0)))
    else $error("timed-out result still drives the motor");

  // Multiplier completions only arrive while the sequencer waits for one.
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> ((state_q == S_SPEED_MUL) || (state_q == S_INT_MUL) ||
                  (state_q == S_INNER_MUL) || (state_q == S_TOTAL_MUL)))
    else $error("multiplier finished outside a multiply step");
`endif

endmodule
